// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/core/tdpn_pkg.sv
package tdpn_pkg;

   localparam int MaxNodesDefault = 64;
   localparam int DataWidth = 32;
   localparam int IntegWidth = 48;
   localparam int CountWidth = 7;

   localparam logic [2:0] RegTopDensity    = 3'd0;
   localparam logic [2:0] RegPeakDensity   = 3'd1;
   localparam logic [2:0] RegBottomDensity = 3'd2;
   localparam logic [2:0] RegPeakHeight    = 3'd3;
   localparam logic [2:0] RegBottomHeight  = 3'd4;
   localparam logic [2:0] RegCellSpacing   = 3'd5;
   localparam logic [2:0] RegNodeCount     = 3'd6;

   localparam logic [31:0] TopDensityReset    = 32'd5243;
   localparam logic [31:0] PeakDensityReset   = 32'd196608;
   localparam logic [31:0] BottomDensityReset = 32'd11796;
   localparam logic [31:0] PeakHeightReset    = 32'd32768;
   localparam logic [31:0] BottomHeightReset  = 32'd6554;
   localparam logic [31:0] CellSpacingReset   = 32'd4096;
   localparam logic [6:0]  NodeCountReset     = 7'd17;

   // Simpson divisor 3 * 65536
   localparam logic [63:0] SimpsonDivisor = 64'd196608;

   // request to the shared multiply-divide unit
   typedef struct packed {
      logic        start;
      logic [63:0] mul_a;
      logic [63:0] mul_b;
      logic [63:0] divisor;
   } mdu_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } mdu_rsp_type;

endpackage

// File: rtl/core/tdpn_muldiv.sv
// floor(a*b/c), low 64 quotient bits, 0 when c is 0.
// Multiply by 16-bit partial products, then one quotient bit per cycle.
module tdpn_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  tdpn_pkg::mdu_req_type req,
   output tdpn_pkg::mdu_rsp_type rsp
);

   typedef enum logic [3:0] {
      MD_IDLE = 4'b0001,
      MD_MUL  = 4'b0010,
      MD_DIV  = 4'b0100,
      MD_DONE = 4'b1000
   } md_state_type;

   md_state_type state_ff, state_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [127:0] prod_ff, prod_in;
   logic [63:0]  rem_ff, rem_in, q_ff, q_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [31:0]  pp;
   logic [64:0]  rem_sh;
   logic [15:0]  a_part, b_part;

   always_comb begin
      a_part = a_ff[cnt_ff[3:2]*16 +: 16];
      b_part = b_ff[cnt_ff[1:0]*16 +: 16];
      pp = a_part * b_part;
      rem_sh = {rem_ff, prod_ff[7'd127 - cnt_ff]};
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               a_in = req.mul_a;
               b_in = req.mul_b;
               c_in = req.divisor;
               prod_in = '0;
               rem_in = '0;
               q_in = '0;
               cnt_in = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            prod_in = prod_ff + ({96'd0, pp} << ({1'b0, cnt_ff[3:2], 4'd0}
                                                + {1'b0, cnt_ff[1:0], 4'd0}));
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd15) begin
               cnt_in = '0;
               state_in = (c_ff == '0) ? MD_DONE : MD_DIV;
            end
         end
         MD_DIV: begin
            q_in = {q_ff[62:0], 1'b0};
            if (rem_sh >= {1'b0, c_ff}) begin
               rem_in = 64'(rem_sh - {1'b0, c_ff});
               q_in[0] = 1'b1;
            end else begin
               rem_in = rem_sh[63:0];
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) state_in = MD_DONE;
         end
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
   end

   assign rsp.done = (state_ff == MD_DONE);
   assign rsp.quotient = q_ff;

endmodule

// File: rtl/core/triangle_density_profile_normalizer.sv
// Triangle density profile normalizer.
// csr_ channel: csr_valid/csr_ready, csr_index selects a register (0 top_density,
// 1 peak_density, 2 bottom_density, 3 peak_height, 4 bottom_height, 5 cell_spacing,
// 6 node_count); the user writes only while idle, unenforced by the block.
// req_ channel: one word carries area_index. rsp_ channel: n words per request,
// node_index 0..n-1, with rsp_tlast on the last node.
// Sloped samples, the integral and every output go through one shared
// multiply-divide unit (16 multiply steps, then 128 divide steps for a nonzero
// divisor); flat samples bypass it. Each item waits on the unit before the next.
// req_tready is high only while the sequencer is idle.
// Reset restores register defaults, clears the integral and idles the sequencer.
// The profile memory needs no clearing: each request rewrites it before reading.
// While the receiver holds rsp_tready low the held word stays; the next word is
// recomputed until the held word drains.
module triangle_density_profile_normalizer #(
   parameter int MAX_NODES = tdpn_pkg::MaxNodesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] area_index
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [5:0] node_index, [37:6] density_value, zeros
   output logic        rsp_tuser,   // [0] zero_integral
   output logic        rsp_tlast    // last_node
);

   localparam int IW = $clog2(MAX_NODES);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SAMP = 7'b0000010,
      ST_SWAIT = 7'b0000100,
      ST_INTEG = 7'b0001000,
      ST_IWAIT = 7'b0010000,
      ST_OUT  = 7'b0100000,
      ST_OWAIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [31:0] top_ff, peak_ff, bot_ff, ph_ff, bh_ff, cs_ff;
   logic [6:0]  nc_ff;
   logic [31:0] area_ff, area_in;
   logic [6:0]  n_ff, n_in, i_ff, i_in;
   logic [47:0] integ_ff, integ_in;
   logic [55:0] sum_ff, sum_in;
   logic        zero_ff, zero_in;
   logic [31:0] base_ff, base_in, first_ff, first_in, h;
   logic        up_ff, up_in;
   logic        pass_ff, pass_in;
   logic [31:0] mem [MAX_NODES];
   logic [31:0] rd_ff;
   logic        we;
   logic        ov_ff, ov_in;
   logic [39:0] out_ff, out_in;
   logic        ol_ff, ol_in, ou_ff, ou_in;
   tdpn_pkg::mdu_req_type mreq;
   tdpn_pkg::mdu_rsp_type mrsp;
   logic [63:0] z, top_h, sval;
   logic [6:0]  nclamp;

   tdpn_muldiv u_mdu (.clock(clock), .reset(reset), .req(mreq), .rsp(mrsp));

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= tdpn_pkg::TopDensityReset;
         peak_ff <= tdpn_pkg::PeakDensityReset;
         bot_ff <= tdpn_pkg::BottomDensityReset;
         ph_ff <= tdpn_pkg::PeakHeightReset;
         bh_ff <= tdpn_pkg::BottomHeightReset;
         cs_ff <= tdpn_pkg::CellSpacingReset;
         nc_ff <= tdpn_pkg::NodeCountReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            tdpn_pkg::RegTopDensity:    top_ff <= csr_data;
            tdpn_pkg::RegPeakDensity:   peak_ff <= csr_data;
            tdpn_pkg::RegBottomDensity: bot_ff <= csr_data;
            tdpn_pkg::RegPeakHeight:    ph_ff <= csr_data;
            tdpn_pkg::RegBottomHeight:  bh_ff <= csr_data;
            tdpn_pkg::RegCellSpacing:   cs_ff <= csr_data;
            tdpn_pkg::RegNodeCount:     nc_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (nc_ff < 7'd3) nclamp = 7'd3;
      else if (nc_ff > 7'(MAX_NODES)) nclamp = 7'(MAX_NODES);
      else nclamp = nc_ff;
   end

   // heights; i*spacing is a narrow-by-wide product only
   assign z = 64'(i_ff) * 64'(cs_ff);
   assign top_h = 64'(n_ff - 7'd1) * 64'(cs_ff);
   assign sval = up_ff ? 64'(base_ff) + mrsp.quotient : 64'(base_ff) - mrsp.quotient;
   assign h = sval[31:0];
   assign we = (state_ff == ST_SWAIT && mrsp.done) || (state_ff == ST_SAMP && z <= 64'(bh_ff));

   always_comb begin
      state_in = state_ff;
      area_in = area_ff;
      n_in = n_ff;
      i_in = i_ff;
      integ_in = integ_ff;
      sum_in = sum_ff;
      zero_in = zero_ff;
      base_in = base_ff;
      up_in = up_ff;
      first_in = first_ff;
      pass_in = pass_ff;
      ov_in = ov_ff;
      out_in = out_ff;
      ol_in = ol_ff;
      ou_in = ou_ff;
      mreq = '0;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               area_in = req_tdata;
               n_in = nclamp;
               i_in = '0;
               sum_in = '0;
               state_in = ST_SAMP;
            end
         end
         ST_SAMP: begin
            if (z <= 64'(bh_ff)) begin
               // flat part written directly
               sum_in = sum_ff + (i_ff[0] ? {22'd0, bot_ff, 2'd0} : {23'd0, bot_ff, 1'b0});
               if (i_ff == 7'd0) first_in = bot_ff;
               i_in = i_ff + 7'd1;
               if (i_ff == n_ff - 7'd1) begin
                  sum_in = sum_ff + (i_ff[0] ? {22'd0, bot_ff, 2'd0} : {23'd0, bot_ff, 1'b0})
                           - 56'(first_ff) - 56'(bot_ff);
                  state_in = ST_INTEG;
               end
            end else begin
               mreq.start = 1'b1;
               if (z <= 64'(ph_ff)) begin
                  up_in = peak_ff >= bot_ff;
                  base_in = bot_ff;
                  mreq.mul_a = z - 64'(bh_ff);
                  mreq.mul_b = 64'(peak_ff >= bot_ff ? peak_ff - bot_ff : bot_ff - peak_ff);
                  mreq.divisor = 64'(ph_ff) - 64'(bh_ff);
               end else begin
                  up_in = top_ff >= peak_ff;
                  base_in = peak_ff;
                  mreq.mul_a = z - 64'(ph_ff);
                  mreq.mul_b = 64'(top_ff >= peak_ff ? top_ff - peak_ff : peak_ff - top_ff);
                  mreq.divisor = top_h - 64'(ph_ff);
               end
               state_in = ST_SWAIT;
            end
         end
         ST_SWAIT: begin
            if (mrsp.done) begin
               sum_in = sum_ff + (i_ff[0] ? {22'd0, h, 2'd0} : {23'd0, h, 1'b0});
               if (i_ff == 7'd0) first_in = h;
               i_in = i_ff + 7'd1;
               state_in = ST_SAMP;
               if (i_ff == n_ff - 7'd1) begin
                  sum_in = sum_ff + (i_ff[0] ? {22'd0, h, 2'd0} : {23'd0, h, 1'b0})
                           - 56'(first_ff) - 56'(h);
                  state_in = ST_INTEG;
               end
            end
         end
         ST_INTEG: begin
            mreq.start = 1'b1;
            mreq.mul_a = 64'(sum_ff);
            mreq.mul_b = 64'(cs_ff);
            mreq.divisor = tdpn_pkg::SimpsonDivisor;
            state_in = ST_IWAIT;
         end
         ST_IWAIT: begin
            if (mrsp.done) begin
               integ_in = (mrsp.quotient[63:48] != '0) ? '1 : mrsp.quotient[47:0];
               zero_in = (mrsp.quotient == '0);
               i_in = '0;
               pass_in = 1'b0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // pass clear reads memory; pass set, as on a stall retry, starts the unit
            if (!pass_ff) begin
               pass_in = 1'b1;
            end else begin
               pass_in = 1'b0;
               mreq.start = 1'b1;
               mreq.mul_a = 64'(area_ff);
               mreq.mul_b = 64'(rd_ff);
               mreq.divisor = zero_ff ? 64'd0 : 64'(integ_ff);
               state_in = ST_OWAIT;
            end
         end
         ST_OWAIT: begin
            if (mrsp.done && (!ov_ff || rsp_tready)) begin
               ov_in = 1'b1;
               out_in = {2'd0, (mrsp.quotient[63:32] != '0) ? 32'hFFFF_FFFF
                         : mrsp.quotient[31:0], i_ff[5:0]};
               ou_in = zero_ff;
               ol_in = (i_ff == n_ff - 7'd1);
               i_in = i_ff + 7'd1;
               state_in = (i_ff == n_ff - 7'd1) ? ST_IDLE : ST_OUT;
            end else if (mrsp.done) begin
               state_in = ST_OUT;
               pass_in = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[i_ff[IW-1:0]] <= (state_ff == ST_SAMP) ? bot_ff : h;
      rd_ff <= mem[i_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         integ_ff <= '0;
         pass_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         integ_ff <= integ_in;
         pass_ff <= pass_in;
      end
      area_ff <= area_in;
      n_ff <= n_in;
      i_ff <= i_in;
      sum_ff <= sum_in;
      zero_ff <= zero_in;
      base_ff <= base_in;
      up_ff <= up_in;
      first_ff <= first_in;
      out_ff <= out_in;
      ol_ff <= ol_in;
      ou_ff <= ou_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tuser = ou_ff;
   assign rsp_tlast = ol_ff;

`include "assert_macros.svh"

   `ASSERT_IMPL(a_ready_idle, clock, reset, req_tready, state_ff == ST_IDLE)
   `ASSERT_IMPL(a_zero_out, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[37:6] == '0)
   `ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

// File: verif/tdpn_checker.sv
module tdpn_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          pending,
   output int          fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [5:0]  node;
      logic [31:0] density;
      logic        zero;
      logic        last;
   } node_word_type;

   node_word_type node_words_due[$];

   logic [31:0] top_dens, peak_dens, bot_dens, peak_ht, bot_ht, spacing;
   logic [6:0]  nodes_cfg;

   function automatic logic [63:0] scaled_ratio(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] c);
      logic [127:0] q;
      if (c == 0) return 64'd0;
      q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
      return q[63:0];
   endfunction

   function automatic logic [31:0] ramp(logic [31:0] base, logic [31:0] target,
                                       logic [63:0] d, logic [63:0] span);
      logic [63:0] step;
      if (target >= base) begin
         step = scaled_ratio(d, {32'd0, target - base}, span);
         return base + step[31:0];
      end
      step = scaled_ratio(d, {32'd0, base - target}, span);
      return base - step[31:0];
   endfunction

   task automatic predict_profile(logic [31:0] area);
      logic [31:0] h [64];
      logic [63:0] z, top, s, integ, v, prod;
      int          n;
      node_word_type w;
      n = nodes_cfg;
      if (n < 3) n = 3;
      if (n > tdpn_pkg::MaxNodesDefault) n = tdpn_pkg::MaxNodesDefault;
      top = 64'(n - 1) * {32'd0, spacing};
      s = 0;
      for (int i = 0; i < n; i++) begin
         z = 64'(i) * {32'd0, spacing};
         if (z <= {32'd0, bot_ht})
            h[i] = bot_dens;
         else if (z <= {32'd0, peak_ht})
            h[i] = ramp(bot_dens, peak_dens, z - bot_ht, {32'd0, peak_ht} - bot_ht);
         else
            h[i] = ramp(peak_dens, top_dens, z - peak_ht, top - peak_ht);
         s += (i % 2 == 1) ? 4 * {32'd0, h[i]} : 2 * {32'd0, h[i]};
      end
      s -= {32'd0, h[0]} + {32'd0, h[n-1]};
      integ = scaled_ratio(s, {32'd0, spacing}, tdpn_pkg::SimpsonDivisor);
      if (integ > 64'hFFFF_FFFF_FFFF) integ = 64'hFFFF_FFFF_FFFF;
      for (int i = 0; i < n; i++) begin
         v = 0;
         if (integ != 0) begin
            prod = {32'd0, area} * {32'd0, h[i]};
            v = prod / integ;
            if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
         end
         w.node = 6'(i);
         w.density = v[31:0];
         w.zero = (integ == 0);
         w.last = (i == n - 1);
         node_words_due.push_back(w);
      end
   endtask

   assign pending = node_words_due.size();

   always @(posedge clock) begin
      node_word_type w;
      if (reset) begin
         top_dens  <= tdpn_pkg::TopDensityReset;
         peak_dens <= tdpn_pkg::PeakDensityReset;
         bot_dens  <= tdpn_pkg::BottomDensityReset;
         peak_ht   <= tdpn_pkg::PeakHeightReset;
         bot_ht    <= tdpn_pkg::BottomHeightReset;
         spacing   <= tdpn_pkg::CellSpacingReset;
         nodes_cfg <= tdpn_pkg::NodeCountReset;
         node_words_due.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tdpn_pkg::RegTopDensity:    top_dens  <= csr_data;
               tdpn_pkg::RegPeakDensity:   peak_dens <= csr_data;
               tdpn_pkg::RegBottomDensity: bot_dens  <= csr_data;
               tdpn_pkg::RegPeakHeight:    peak_ht   <= csr_data;
               tdpn_pkg::RegBottomHeight:  bot_ht    <= csr_data;
               tdpn_pkg::RegCellSpacing:   spacing   <= csr_data;
               tdpn_pkg::RegNodeCount:     nodes_cfg <= csr_data[6:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_profile(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (node_words_due.size() == 0) begin
               $error("unexpected result word node_index=%0d", rsp_tdata[5:0]);
               fail_count <= fail_count + 1;
            end else begin
               w = node_words_due.pop_front();
               if (rsp_tdata[5:0] !== w.node || rsp_tdata[37:6] !== w.density ||
                   rsp_tuser !== w.zero || rsp_tlast !== w.last)
                  fail_count <= fail_count + 1;
               if (rsp_tdata[5:0] !== w.node)
                  $error("node_index expected %0d actual %0d", w.node, rsp_tdata[5:0]);
               if (rsp_tdata[37:6] !== w.density)
                  $error("density_value expected %h actual %h", w.density,
                         rsp_tdata[37:6]);
               if (rsp_tuser !== w.zero)
                  $error("zero_integral expected %b actual %b", w.zero, rsp_tuser);
               if (rsp_tlast !== w.last)
                  $error("last_node expected %b actual %b", w.last, rsp_tlast);
            end
         end
      end
   end
endmodule

// File: verif/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 20000000;
   localparam int SettleCycles = 400;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   int          pending;
   int          fail_count;
   int          cycle = 0;
   int          sent = 0;

   always #2 clock = ~clock;

   triangle_density_profile_normalizer dut (.*);

   tdpn_checker chk (.*);

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > CycleLimit) begin
         $display("triangle_density_profile_normalizer verification failed");
         $finish;
      end
   end

   // no random idling on either side during this window
   function automatic bit quiet_window();
      return cycle >= 60000 && cycle < 90000;
   endfunction

   // receiver: random stalls plus one long hold-off
   initial begin
      int ticks;
      ticks = 0;
      forever begin
         @(posedge clock);
         ticks++;
         if (ticks >= 25000 && ticks < 31000)
            rsp_tready <= 0;
         else
            rsp_tready <= quiet_window() || ($urandom_range(99) >= 17);
      end
   end

   task automatic send_area(logic [31:0] area);
      while (!quiet_window() && $urandom_range(99) < 17) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= area;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic write_profile(logic [31:0] td, logic [31:0] pd, logic [31:0] bd,
                                logic [31:0] ph, logic [31:0] bh, logic [31:0] cs,
                                logic [31:0] nc);
      write_reg(tdpn_pkg::RegTopDensity, td);
      write_reg(tdpn_pkg::RegPeakDensity, pd);
      write_reg(tdpn_pkg::RegBottomDensity, bd);
      write_reg(tdpn_pkg::RegPeakHeight, ph);
      write_reg(tdpn_pkg::RegBottomHeight, bh);
      write_reg(tdpn_pkg::RegCellSpacing, cs);
      write_reg(tdpn_pkg::RegNodeCount, nc);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic logic [31:0] spread32();
      return $urandom >> $urandom_range(31, 0);
   endfunction

   function automatic logic [31:0] random_area();
      return ($urandom_range(9) == 0) ? $urandom : spread32();
   endfunction

   initial begin
      logic [31:0] nc, cs;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset profile, area extremes
      send_area(32'h0);
      send_area(32'hFFFF_FFFF);
      send_area(32'h1);
      send_area(32'h0001_0000);
      send_area($urandom);
      drain();

      // all-ones densities, peak not above bottom, node count clamped up
      write_profile('1, '1, '1, 0, 0, 1, 0);
      send_area(32'hFFFF_FFFF);
      send_area($urandom);
      send_area(32'h0);
      drain();

      // all densities zero gives zero integral
      write_profile(0, 0, 0, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 5);
      send_area(32'hFFFF_FFFF);
      send_area($urandom);
      drain();

      // zero spacing
      write_profile($urandom, $urandom, $urandom, $urandom, $urandom, 0, 2);
      send_area($urandom);
      send_area(32'hFFFF_FFFF);
      drain();

      // maximum spacing and heights, node count clamped down
      write_profile($urandom, $urandom, $urandom, '1, '1, '1, 127);
      send_area($urandom);
      drain();

      write_profile(tdpn_pkg::TopDensityReset, tdpn_pkg::PeakDensityReset,
                    tdpn_pkg::BottomDensityReset, tdpn_pkg::PeakHeightReset,
                    tdpn_pkg::BottomHeightReset, tdpn_pkg::CellSpacingReset, 64);
      send_area(32'h0003_0000);
      drain();

      // peak below bottom
      write_profile(32'h0000_1000, 32'h0004_0000, 32'h0000_2000, 1000, 50000,
                    32'h0000_2000, 9);
      send_area(32'h0002_0000);
      send_area($urandom);
      drain();

      while (sent < 160) begin
         case ($urandom_range(19))
            0:       nc = $urandom_range(0, 2);
            1:       nc = $urandom_range(64, 127);
            default: nc = $urandom_range(3, 9);
         endcase
         cs = spread32();
         if (cs == 0) cs = 1;
         write_profile(spread32(), spread32(), spread32(), spread32(), spread32(),
                       cs, nc);
         repeat ($urandom_range(4, 8)) send_area(random_area());
         drain();
      end

      if (fail_count == 0)
         $display("triangle_density_profile_normalizer verification clean");
      else
         $display("triangle_density_profile_normalizer verification failed");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/tdpn_pkg.sv
rtl/core/tdpn_muldiv.sv
rtl/core/triangle_density_profile_normalizer.sv
verif/tdpn_checker.sv
verif/tb_top.sv
